>>> rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every rising edge outside reset
`define BBA_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("bba check failed");

// condition that must never be seen outside reset
`define BBA_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error("bba forbidden condition");

`endif

>>> rtl/bba_pkg.sv
`default_nettype none
package bba_pkg;

	localparam int MAX_LEVELS = 8;
	localparam int LVL_W      = $clog2(MAX_LEVELS);
	localparam int IDX_W      = MAX_LEVELS - 1;
	localparam int POOL       = 1 << IDX_W;
	localparam int CFG_W      = 4;

	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_NOFIT   = 2'd1;
	localparam logic [1:0] STAT_BADFREE = 2'd2;

	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	localparam logic [CFG_W-1:0] LEVELS_RESET = 4'd8;

	typedef struct packed {
		logic        operation;
		logic [15:0] request_bytes;
		logic [6:0]  block_index;
	} in_item_t;

	typedef struct packed {
		logic [1:0] status;
		logic [6:0] result_index;
		logic [2:0] result_level;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_SPLIT,
		ST_LOOKUP,
		ST_MINIT,
		ST_MERGE,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic accept;
		logic search_next;
		logic search_take;
		logic split_step;
		logic alloc_commit;
		logic fail_nofit;
		logic fail_bad;
		logic free_start;
		logic merge_step;
		logic merge_end;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic found;
		logic at_top;
		logic split_more;
		logic free_bad;
		logic merge_more;
	} sts_t;

	// top level index for a register value, range clamped
	function automatic logic [LVL_W-1:0] top_of(input logic [CFG_W-1:0] v);
		logic [LVL_W-1:0] r;
		if (v == '0)
			r = '0;
		else if (v > CFG_W'(MAX_LEVELS))
			r = LVL_W'(MAX_LEVELS - 1);
		else
			r = LVL_W'(v - 4'd1);
		return r;
	endfunction

	function automatic logic [31:0] capacity(input logic [LVL_W-1:0] k,
		input int unsigned chunk, input int unsigned header);
		return (32'(chunk) << k) - 32'(header);
	endfunction

endpackage
`default_nettype wire

>>> rtl/bba_ram.sv
`default_nettype none
module bba_ram #(
	parameter int WIDTH = 3,
	parameter int DEPTH = 128
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]              rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

>>> rtl/bba_ctrl.sv
`default_nettype none
module bba_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	input  wire logic            in_op,
	input  wire logic            out_stall,
	input  wire bba_pkg::sts_t   sts,
	output bba_pkg::cmd_t        cmd,
	output logic                 in_stall,
	output logic                 out_valid,
	output bba_pkg::state_t      state
);
	bba_pkg::state_t state_q, state_d;
	logic out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= bba_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			bba_pkg::ST_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d = (in_op == bba_pkg::OP_FREE) ? bba_pkg::ST_LOOKUP
						: bba_pkg::ST_SEARCH;
				end
			end
			bba_pkg::ST_SEARCH: begin
				if (sts.found) begin
					cmd.search_take = 1'b1;
					state_d = bba_pkg::ST_SPLIT;
				end else if (sts.at_top) begin
					cmd.fail_nofit = 1'b1;
					state_d = bba_pkg::ST_DONE;
				end else begin
					cmd.search_next = 1'b1;
				end
			end
			bba_pkg::ST_SPLIT: begin
				if (sts.split_more) begin
					cmd.split_step = 1'b1;
				end else begin
					cmd.alloc_commit = 1'b1;
					state_d = bba_pkg::ST_DONE;
				end
			end
			bba_pkg::ST_LOOKUP: begin
				if (sts.free_bad) begin
					cmd.fail_bad = 1'b1;
					state_d = bba_pkg::ST_DONE;
				end else begin
					state_d = bba_pkg::ST_MINIT;
				end
			end
			bba_pkg::ST_MINIT: begin
				cmd.free_start = 1'b1;
				state_d = bba_pkg::ST_MERGE;
			end
			bba_pkg::ST_MERGE: begin
				if (sts.merge_more) begin
					cmd.merge_step = 1'b1;
				end else begin
					cmd.merge_end = 1'b1;
					state_d = bba_pkg::ST_DONE;
				end
			end
			bba_pkg::ST_DONE: begin
				if (!out_valid_q || !out_stall) begin
					cmd.out_load = 1'b1;
					state_d = bba_pkg::ST_IDLE;
				end
			end
			default: state_d = bba_pkg::ST_IDLE;
		endcase
	end

	assign in_stall  = (state_q != bba_pkg::ST_IDLE);
	assign out_valid = out_valid_q;
	assign state     = state_q;
endmodule
`default_nettype wire

>>> rtl/bba_datapath.sv
`default_nettype none
module bba_datapath #(
	parameter int CHUNK_BYTES  = 16,
	parameter int HEADER_BYTES = 8
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [bba_pkg::CFG_W-1:0]    cfg_data,
	input  wire bba_pkg::in_item_t            in_item,
	input  wire bba_pkg::cmd_t                cmd,
	output bba_pkg::sts_t                     sts,
	output bba_pkg::out_item_t                out_item
);
	localparam int LW = bba_pkg::LVL_W;
	localparam int IW = bba_pkg::IDX_W;
	// free row holding only the block at start 0
	localparam logic [bba_pkg::POOL-1:0] BLK0 = {{(bba_pkg::POOL-1){1'b0}}, 1'b1};
	localparam logic [LW-1:0] RESET_TOP = bba_pkg::top_of(bba_pkg::LEVELS_RESET);

	logic [bba_pkg::POOL-1:0] free_q [bba_pkg::MAX_LEVELS];
	logic [bba_pkg::POOL-1:0] alloc_q;
	logic [bba_pkg::CFG_W-1:0] levels_q;
	logic [15:0]   size_q;
	logic [IW-1:0] idx_q;
	logic [LW-1:0] k_q;
	logic [1:0]    res_status_q;
	logic [IW-1:0] res_idx_q;
	logic [LW-1:0] res_lev_q;
	bba_pkg::out_item_t out_q;

	logic [LW-1:0] top;
	logic [LW-1:0] cfg_top;
	logic [bba_pkg::POOL-1:0] row;
	logic [IW-1:0] first;
	logic          fits;
	logic [LW-1:0] k_dn;
	logic [IW-1:0] half;
	logic [IW-1:0] bit_k;
	logic [LW-1:0] rd_lev;
	logic [LW-1:0] start_lev;

	assign top     = bba_pkg::top_of(levels_q);
	assign cfg_top = bba_pkg::top_of(cfg_data);
	assign row     = free_q[k_q];
	assign fits    = bba_pkg::capacity(k_q, CHUNK_BYTES, HEADER_BYTES) >= {16'd0, size_q};
	assign k_dn    = k_q - LW'(1);
	assign half    = IW'(1) << k_dn;
	assign bit_k   = IW'(1) << k_q;
	assign start_lev = (rd_lev > top) ? top : rd_lev;

	// lowest free block on the current level
	always_comb begin
		first = '0;
		for (int i = bba_pkg::POOL - 1; i >= 0; i--) begin
			if (row[i])
				first = IW'(i);
		end
	end

	always_comb begin
		sts.found      = fits && (|row);
		sts.at_top     = (k_q == top);
		sts.split_more = (k_q != '0) &&
			(bba_pkg::capacity(k_dn, CHUNK_BYTES, HEADER_BYTES) >= {16'd0, size_q});
		sts.free_bad   = ((idx_q >> top) != '0) || !alloc_q[idx_q];
		sts.merge_more = (k_q < top) && row[idx_q ^ bit_k];
	end

	bba_ram #(.WIDTH(LW), .DEPTH(bba_pkg::POOL)) u_lvl_ram (
		.clk   (clk),
		.we    (cmd.alloc_commit),
		.waddr (idx_q),
		.wdata (k_q),
		.raddr (idx_q),
		.rdata (rd_lev)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int l = 0; l < bba_pkg::MAX_LEVELS; l++)
				free_q[l] <= (LW'(l) == RESET_TOP) ? BLK0 : '0;
			alloc_q  <= '0;
			levels_q <= bba_pkg::LEVELS_RESET;
		end else if (cfg_we) begin
			for (int l = 0; l < bba_pkg::MAX_LEVELS; l++)
				free_q[l] <= (LW'(l) == cfg_top) ? BLK0 : '0;
			alloc_q  <= '0;
			levels_q <= cfg_data;
		end else begin
			if (cmd.search_take)
				free_q[k_q][first] <= 1'b0;
			if (cmd.split_step)
				free_q[k_dn][idx_q | half] <= 1'b1;
			if (cmd.alloc_commit)
				alloc_q[idx_q] <= 1'b1;
			if (cmd.free_start)
				alloc_q[idx_q] <= 1'b0;
			if (cmd.merge_step)
				free_q[k_q][idx_q ^ bit_k] <= 1'b0;
			if (cmd.merge_end)
				free_q[k_q][idx_q] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			size_q <= in_item.request_bytes;
			idx_q  <= in_item.block_index;
			k_q    <= '0;
		end
		if (cmd.search_next)
			k_q <= k_q + LW'(1);
		if (cmd.search_take)
			idx_q <= first;
		if (cmd.split_step)
			k_q <= k_dn;
		if (cmd.alloc_commit) begin
			res_status_q <= bba_pkg::STAT_OK;
			res_idx_q    <= idx_q;
			res_lev_q    <= k_q;
		end
		if (cmd.fail_nofit) begin
			res_status_q <= bba_pkg::STAT_NOFIT;
			res_idx_q    <= '0;
			res_lev_q    <= '0;
		end
		if (cmd.fail_bad) begin
			res_status_q <= bba_pkg::STAT_BADFREE;
			res_idx_q    <= idx_q;
			res_lev_q    <= '0;
		end
		if (cmd.free_start) begin
			k_q          <= start_lev;
			res_status_q <= bba_pkg::STAT_OK;
			res_idx_q    <= idx_q;
			res_lev_q    <= start_lev;
		end
		if (cmd.merge_step) begin
			idx_q <= idx_q & ~bit_k;
			k_q   <= k_q + LW'(1);
		end
		if (cmd.out_load) begin
			out_q.status       <= res_status_q;
			out_q.result_index <= res_idx_q;
			out_q.result_level <= res_lev_q;
		end
	end

	assign out_item = out_q;
endmodule
`default_nettype wire

>>> rtl/buddy_block_allocator.sv
// channel   signals                      accepted when
// in        in_valid  in_stall  in_item  in_valid high, in_stall low
// out       out_valid out_stall out_item out_valid high, out_stall low
// cfg       cfg_we    cfg_data           cfg_we high
// an allocate steps through the levels searched and then the splits, a free through lookup, init and the merges,
// a bad free through lookup alone; the per-level walk of the free map sets how long an item takes
// reset clears the free map to the single whole-pool block and all allocation marks
// the next item is taken as soon as the previous result sits in the output register
// a held result waits under out_stall without blocking work on the next item
`default_nettype none
`include "assert_macros.svh"
module buddy_block_allocator #(
	parameter int CHUNK_BYTES  = 16,
	parameter int HEADER_BYTES = 8
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      cfg_we,
	input  wire logic [bba_pkg::CFG_W-1:0] cfg_data,
	input  wire logic                      in_valid,
	output logic                           in_stall,
	input  wire bba_pkg::in_item_t         in_item,
	output logic                           out_valid,
	input  wire logic                      out_stall,
	output bba_pkg::out_item_t             out_item
);
	bba_pkg::cmd_t   cmd;
	bba_pkg::sts_t   sts;
	bba_pkg::state_t state;
	logic            nofit_nonzero;

	// sequencer: level search, split and merge walks
	bba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_op     (in_item.operation),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.state     (state)
	);

	// free map, allocation marks, level store and result register
	bba_datapath #(
		.CHUNK_BYTES  (CHUNK_BYTES),
		.HEADER_BYTES (HEADER_BYTES)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data),
		.in_item  (in_item),
		.cmd      (cmd),
		.sts      (sts),
		.out_item (out_item)
	);

	// no-fit result with a non-zero index or level
	assign nofit_nonzero = (out_item.status == bba_pkg::STAT_NOFIT) &&
		((out_item.result_index != '0) || (out_item.result_level != '0));

	// an accepted item keeps the input side busy for the next cycle
	`BBA_ASSERT(a_busy_after_accept, clk, arst_n, (in_valid && !in_stall) |=> in_stall)
	// a new result only appears after the finishing state
	`BBA_ASSERT(a_result_from_done, clk, arst_n, $rose(out_valid) |-> $past(state == bba_pkg::ST_DONE))
	// a failed allocation carries zero index and level
	`BBA_NEVER(a_nofit_zero, clk, arst_n, out_valid && nofit_nonzero)
endmodule
`default_nettype wire

>>> test/tb_buddy_block_allocator.sv
`timescale 1ns / 100ps
module tb_buddy_block_allocator;

	localparam int CHUNK  = 16;
	localparam int HEADER = 8;
	localparam int WATCHDOG_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [bba_pkg::CFG_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	bba_pkg::in_item_t in_item = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	bba_pkg::out_item_t out_item;

	always #4 clk = ~clk;

	buddy_block_allocator uut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
	);

	// predictor state: free flag per level and start, recorded level, allocation mark
	logic free_flag [bba_pkg::MAX_LEVELS][bba_pkg::POOL];
	logic [2:0] alloc_level [bba_pkg::POOL];
	logic alloc_mark [bba_pkg::POOL];
	logic [bba_pkg::CFG_W-1:0] levels_reg;

	bba_pkg::out_item_t pending_results [$];
	int fail_count = 0;
	int results_seen = 0;
	int items_sent = 0;
	int nofit_seen = 0;
	int badfree_seen = 0;
	int idle_pct = 29; // percentage of cycles in which each side idles
	int quiet_cycles = 0;
	// starts of blocks currently held, so most frees hit live blocks
	int held_blocks [$];

	function automatic int active_levels();
		if (levels_reg == 0)
			return 1;
		if (levels_reg > bba_pkg::MAX_LEVELS)
			return bba_pkg::MAX_LEVELS;
		return int'(levels_reg);
	endfunction

	function automatic longint block_bytes(int k);
		return (longint'(CHUNK) << k) - HEADER;
	endfunction

	// whole pool free as one top block
	function automatic void pool_clear();
		for (int k = 0; k < bba_pkg::MAX_LEVELS; k++)
			for (int s = 0; s < bba_pkg::POOL; s++)
				free_flag[k][s] = 1'b0;
		for (int s = 0; s < bba_pkg::POOL; s++) begin
			alloc_level[s] = '0;
			alloc_mark[s] = 1'b0;
		end
		free_flag[active_levels() - 1][0] = 1'b1;
	endfunction

	function automatic bba_pkg::out_item_t predict_alloc(int unsigned size);
		bba_pkg::out_item_t r;
		int lv, pool, k, idx;
		bit found;
		r = '0;
		lv = active_levels();
		pool = 1 << (lv - 1);
		found = 0;
		idx = 0;
		for (k = 0; k < lv && !found; k++) begin
			if (block_bytes(k) < size)
				continue;
			for (int s = 0; s < pool; s += (1 << k))
				if (free_flag[k][s]) begin
					idx = s;
					found = 1;
					break;
				end
			if (found)
				break;
		end
		if (!found) begin
			r.status = bba_pkg::STAT_NOFIT;
			return r;
		end
		free_flag[k][idx] = 1'b0;
		// split down, freeing each right half
		while (k > 0 && block_bytes(k - 1) >= size) begin
			k--;
			free_flag[k][idx + (1 << k)] = 1'b1;
		end
		alloc_mark[idx] = 1'b1;
		alloc_level[idx] = 3'(k);
		r.status = bba_pkg::STAT_OK;
		r.result_index = 7'(idx);
		r.result_level = 3'(k);
		return r;
	endfunction

	function automatic bba_pkg::out_item_t predict_free(int idx);
		bba_pkg::out_item_t r;
		int lv, k, cur, buddy;
		r = '0;
		lv = active_levels();
		r.result_index = 7'(idx);
		if (idx >= (1 << (lv - 1)) || !alloc_mark[idx]) begin
			r.status = bba_pkg::STAT_BADFREE;
			return r;
		end
		k = alloc_level[idx];
		if (k > lv - 1)
			k = lv - 1;
		r.status = bba_pkg::STAT_OK;
		r.result_level = 3'(k);
		alloc_mark[idx] = 1'b0;
		cur = idx;
		// coalesce with free buddies, stopping at the top block
		while (k < lv - 1) begin
			buddy = cur ^ (1 << k);
			if (!free_flag[k][buddy])
				break;
			free_flag[k][buddy] = 1'b0;
			if (buddy < cur)
				cur = buddy;
			k++;
		end
		free_flag[k][cur] = 1'b1;
		return r;
	endfunction

	// one item: predict on acceptance, track held blocks
	task automatic send_item(logic op, logic [15:0] bytes, logic [6:0] idx);
		bba_pkg::in_item_t it;
		bba_pkg::out_item_t r;
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		it.operation = op;
		it.request_bytes = bytes;
		it.block_index = idx;
		in_item <= it;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		if (op == bba_pkg::OP_ALLOC) begin
			r = predict_alloc(bytes);
			if (r.status == bba_pkg::STAT_OK)
				held_blocks.push_back(r.result_index);
		end else begin
			r = predict_free(idx);
			if (r.status == bba_pkg::STAT_OK)
				foreach (held_blocks[i])
					if (held_blocks[i] == idx) begin
						held_blocks.delete(i);
						break;
					end
		end
		pending_results.push_back(r);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (2 * bba_pkg::MAX_LEVELS + 8) @(negedge clk);
	endtask

	task automatic write_levels(logic [bba_pkg::CFG_W-1:0] v);
		wait_drained();
		cfg_data <= v;
		cfg_we <= 1'b1;
		@(negedge clk);
		cfg_we <= 1'b0;
		levels_reg = v;
		pool_clear();
		held_blocks.delete();
	endtask

	// result checker
	always @(posedge clk) begin
		bba_pkg::out_item_t exp_r;
		if (out_valid && !out_stall) begin
			quiet_cycles = 0;
			results_seen++;
			if (pending_results.size() == 0) begin
				$error("result with nothing expected: %p", out_item);
				fail_count++;
			end else begin
				exp_r = pending_results.pop_front();
				if (out_item.status == bba_pkg::STAT_NOFIT)
					nofit_seen++;
				if (out_item.status == bba_pkg::STAT_BADFREE)
					badfree_seen++;
				if (out_item.status !== exp_r.status) begin
					$error("status: expected %0d, got %0d", exp_r.status, out_item.status);
					fail_count++;
				end
				if (out_item.result_index !== exp_r.result_index) begin
					$error("result_index: expected %0d, got %0d",
						exp_r.result_index, out_item.result_index);
					fail_count++;
				end
				if (out_item.result_level !== exp_r.result_level) begin
					$error("result_level: expected %0d, got %0d",
						exp_r.result_level, out_item.result_level);
					fail_count++;
				end
			end
		end else if (in_valid && !in_stall) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
	end

	// receiver stall, changed at the falling edge
	always @(negedge clk)
		out_stall <= ($urandom_range(99) < idle_pct);

	// watchdog over cycles with no progress
	always @(posedge clk)
		if (arst_n && quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
			$display("TEST FAILED");
			$finish;
		end

	// extremes of every field, both operations, each special case
	task automatic test_directed();
		send_item(bba_pkg::OP_ALLOC, 16'd0, 7'd0);     // smallest request
		send_item(bba_pkg::OP_ALLOC, 16'd8, 7'h7f);    // exactly fills level 0
		send_item(bba_pkg::OP_ALLOC, 16'd9, 7'd0);     // needs level 1
		send_item(bba_pkg::OP_ALLOC, 16'hffff, 7'd0);  // nothing fits
		send_item(bba_pkg::OP_ALLOC, 16'd2040, 7'd0);  // top block already split
		send_item(bba_pkg::OP_FREE, 16'hffff, 7'd1);   // free, buddy still held
		send_item(bba_pkg::OP_FREE, 16'd0, 7'd0);      // free, one merge
		send_item(bba_pkg::OP_FREE, 16'd0, 7'd0);      // double free
		send_item(bba_pkg::OP_FREE, 16'd0, 7'd127);    // never allocated
		send_item(bba_pkg::OP_FREE, 16'd0, 7'd2);      // merges up to the top
		send_item(bba_pkg::OP_ALLOC, 16'd2040, 7'd0);  // whole pool
		send_item(bba_pkg::OP_ALLOC, 16'd0, 7'd0);     // pool exhausted
		send_item(bba_pkg::OP_FREE, 16'd0, 7'd3);      // not a block start
		send_item(bba_pkg::OP_FREE, 16'd0, 7'd0);
		for (int i = 0; i < 6; i++)
			send_item(bba_pkg::OP_ALLOC, 16'(8 << i), 7'd0);
		for (int i = 0; i < 6; i++)
			send_item(bba_pkg::OP_FREE, 16'd0, 7'(held_blocks[0]));
	endtask

	// level counts at the edges, including out-of-range values
	task automatic test_level_extremes();
		logic [bba_pkg::CFG_W-1:0] vals [5] = '{4'd0, 4'd1, 4'd15, 4'd9, 4'd2};
		foreach (vals[v]) begin
			write_levels(vals[v]);
			send_item(bba_pkg::OP_ALLOC, 16'd8, 7'd0);
			send_item(bba_pkg::OP_ALLOC, 16'd24, 7'd0);
			send_item(bba_pkg::OP_ALLOC, 16'd0, 7'd0);
			send_item(bba_pkg::OP_FREE, 16'd0, 7'd1);
			send_item(bba_pkg::OP_FREE, 16'd0, 7'd0);
			send_item(bba_pkg::OP_FREE, 16'd0, 7'd64);   // outside a small pool
		end
	endtask

	// mostly allocate/free traffic on live blocks, some noise
	task automatic test_random(int n, logic [bba_pkg::CFG_W-1:0] lv);
		int pick, sh;
		write_levels(lv);
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(99);
			if (pick < 50) begin
				sh = $urandom_range(7);
				send_item(bba_pkg::OP_ALLOC,
					16'($urandom_range((CHUNK << sh) - HEADER)), 7'($urandom));
			end else if (pick < 55) begin
				send_item(bba_pkg::OP_ALLOC, 16'($urandom), 7'($urandom));
			end else if (pick < 92 && held_blocks.size() != 0) begin
				send_item(bba_pkg::OP_FREE, 16'($urandom),
					7'(held_blocks[$urandom_range(held_blocks.size() - 1)]));
			end else begin
				send_item(bba_pkg::OP_FREE, 16'($urandom), 7'($urandom));
			end
			if (i == n / 2) begin
				// sender holds off until all results are back
				in_valid <= 1'b0;
				@(negedge clk);
				while (pending_results.size() != 0)
					@(negedge clk);
			end
		end
	endtask

	initial begin
		levels_reg = bba_pkg::LEVELS_RESET;
		pool_clear();
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_level_extremes();
		test_random(700, 4'd8);
		test_random(300, 4'd3);
		test_random(300, 4'd5);
		idle_pct = 0;                                 // no idling on either side
		test_random(300, 4'd8);
		idle_pct = 29;
		test_random(250, 4'd7);
		wait_drained();
		$display("%0d items sent, %0d results checked (%0d no-fit, %0d bad free)",
			items_sent, results_seen, nofit_seen, badfree_seen);
		$display("level counts 0, 1, 2, 3, 5, 7, 8, 9 and 15 exercised");
		if (fail_count == 0 && pending_results.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
